// ----- rtl/core/pbrle_pkg.sv -----
package pbrle_pkg;

    // default sizes of the coder
    localparam int MAX_SPAN_DEF      = 128;
    localparam int WORD_BYTES_DEF    = 8;
    localparam int LIT_RAM_DEPTH_DEF = 2 * MAX_SPAN_DEF;

    // fixed widths of the port fields and of the code fields
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 8;
    localparam int OUT_W     = 64;
    localparam int OUT_CNT_W = 4;

    // shortest run that is coded as a run
    localparam int MIN_RUN = 2;

    // run header is (257 - length) mod 256
    localparam logic [8:0] RUN_HDR_BASE = 9'd257;

    // depth of the code queue between front and back
    localparam int CMDQ_DEPTH = 4;

    typedef enum logic {
        CMD_RUN,
        CMD_LIT
    } t_cmd_kind;

    // one code to emit; a literal reads len bytes from bank of the literal ram,
    // then the inline tail byte if has_tail is set
    typedef struct packed {
        t_cmd_kind          kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic               has_tail;
        logic               bank;
        logic               burst_end;
        logic               stream_end;
    } t_cmd;

    // back tells front that a literal bank has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } t_lit_release;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_RUN,
        BK_LIT,
        BK_TAIL
    } t_back_state;

endpackage

// ----- rtl/core/packbits_rle_encoder_top.sv -----
// packbits run-length encoder
//
// input channel: one raw byte per word (i_in_byte), i_in_last on the final
// byte of a stream; accepted when i_valid and o_ready are both high
// output channel: words of up to WORD_BYTES coded bytes, first byte in bits
// 7..0, lanes above o_out_count are zero; o_out_end marks the word holding the
// final coded byte of the stream; taken when o_valid and i_ready are high
// the coded bytes that one input word causes are packed on their own, so only
// the last output word of that group can be partial
// front: takes one byte per cycle; a byte that closes two codes holds o_ready
// low until the second code is pushed, and o_ready stays low while the code
// queue is full or the literal bank it would fill is still being read out by
// the back (two banks of MAX_SPAN bytes)
// back: one coded byte per cycle while the receiver keeps up; each code is
// first popped from the code queue in the idle state
// a code passes the code queue, sequencer, byte stage and output register
// reset (synchronous, active low) drops any partial stream and empties the
// queue; the literal ram needs no clearing
// a stalled receiver fills the output register, then the byte stage, then
// the code queue, and finally o_ready drops
module packbits_rle_encoder_top #(
    parameter int MAX_SPAN   = pbrle_pkg::MAX_SPAN_DEF,
    parameter int WORD_BYTES = pbrle_pkg::WORD_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pbrle_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                            i_in_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pbrle_pkg::OUT_W-1:0]     o_out_word,
    output logic [pbrle_pkg::OUT_CNT_W-1:0] o_out_count,
    output logic                            o_out_end
);

    import pbrle_pkg::*;

    // two literal banks side by side in one ram
    localparam int ADDR_W    = $clog2(MAX_SPAN) + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // front to queue
    logic q_push, q_full, q_pop, q_empty;
    t_cmd push_cmd, head_cmd;

    // literal ram
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;

    // back frees a bank once its last byte is read
    t_lit_release release_s;

    pbrle_front #(
        .MAX_SPAN(MAX_SPAN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_push     (q_push),
        .o_push_cmd (push_cmd),
        .i_q_full   (q_full),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_release  (release_s)
    );

    pbrle_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_lit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pbrle_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    pbrle_back #(
        .MAX_SPAN   (MAX_SPAN),
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (release_s),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_word  (o_out_word),
        .o_out_count (o_out_count),
        .o_out_end   (o_out_end)
    );

endmodule

// ----- rtl/core/pbrle_ram.sv -----
module pbrle_ram #(
    parameter int WIDTH = pbrle_pkg::BYTE_W,
    parameter int DEPTH = pbrle_pkg::LIT_RAM_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/pbrle_front.sv -----
module pbrle_front #(
    parameter int MAX_SPAN = pbrle_pkg::MAX_SPAN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pbrle_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                           i_in_last,
    output logic                           o_push,
    output pbrle_pkg::t_cmd                o_push_cmd,
    input  logic                           i_q_full,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_SPAN):0]      o_wr_addr,
    output logic [pbrle_pkg::BYTE_W-1:0]   o_wr_data,
    input  pbrle_pkg::t_lit_release        i_release
);

    import pbrle_pkg::*;

    localparam int IDX_W = $clog2(MAX_SPAN);
    localparam int CNT_W = $clog2(MAX_SPAN + 1);

    function automatic t_cmd f_run_cmd(input logic [LEN_W-1:0] len,
                                       input logic [BYTE_W-1:0] data);
        t_cmd c;
        c      = '0;
        c.kind = CMD_RUN;
        c.len  = len;
        c.data = data;
        return c;
    endfunction

    function automatic t_cmd f_lit_cmd(input logic bank, input logic [LEN_W-1:0] len,
                                       input logic has_tail, input logic [BYTE_W-1:0] data);
        t_cmd c;
        c          = '0;
        c.kind     = CMD_LIT;
        c.bank     = bank;
        c.len      = len;
        c.has_tail = has_tail;
        c.data     = data;
        return c;
    endfunction

    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_held_v, n_held_v;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [CNT_W-1:0]  r_lit, n_lit;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;
    logic              r_pend_v;
    t_cmd              r_pend;

    logic accept;
    logic set_busy;
    logic cmd_a_v, cmd_b_v;
    t_cmd cmd_a, cmd_b, flush_cmd;

    assign o_ready = !r_pend_v && !i_q_full && !r_busy[r_bank];
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_run     = r_run;
        n_lit     = r_lit;
        n_bank    = r_bank;
        cmd_a     = '0;
        cmd_b     = '0;
        cmd_a_v   = 1'b0;
        cmd_b_v   = 1'b0;
        flush_cmd = '0;
        set_busy  = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = {r_bank, r_lit[IDX_W-1:0]};
        o_wr_data = r_held;
        if (accept) begin
            if (!r_held_v) begin
                n_held   = i_in_byte;
                n_held_v = 1'b1;
            end else if (r_run != '0) begin
                if (i_in_byte == r_held && r_run < CNT_W'(MAX_SPAN)) begin
                    n_run = CNT_W'(r_run + 1'b1);
                end else begin
                    cmd_a   = f_run_cmd(LEN_W'(r_run), r_held);
                    cmd_a_v = 1'b1;
                    n_run   = '0;
                    n_held  = i_in_byte;
                end
            end else if (i_in_byte == r_held) begin
                // two equal bytes close the literal and open a run
                if (r_lit != '0) begin
                    cmd_a    = f_lit_cmd(r_bank, LEN_W'(r_lit), 1'b0, '0);
                    cmd_a_v  = 1'b1;
                    set_busy = 1'b1;
                    n_bank   = ~r_bank;
                    n_lit    = '0;
                end
                n_run = CNT_W'(MIN_RUN);
            end else begin
                o_wr_en = 1'b1;
                if (r_lit == CNT_W'(MAX_SPAN - 1)) begin
                    cmd_a    = f_lit_cmd(r_bank, LEN_W'(MAX_SPAN), 1'b0, '0);
                    cmd_a_v  = 1'b1;
                    set_busy = 1'b1;
                    n_bank   = ~r_bank;
                    n_lit    = '0;
                end else begin
                    n_lit = CNT_W'(r_lit + 1'b1);
                end
                n_held = i_in_byte;
            end

            if (i_in_last) begin
                // flush: closes an open run, else the held byte goes inline as the literal tail
                if (n_run != '0) begin
                    flush_cmd = f_run_cmd(LEN_W'(n_run), n_held);
                end else begin
                    flush_cmd = f_lit_cmd(n_bank, LEN_W'(n_lit), 1'b1, n_held);
                    if (n_lit != '0) begin
                        set_busy = 1'b1;
                        n_bank   = ~n_bank;
                    end
                end
                flush_cmd.stream_end = 1'b1;
                if (cmd_a_v) begin
                    cmd_b   = flush_cmd;
                    cmd_b_v = 1'b1;
                end else begin
                    cmd_a   = flush_cmd;
                    cmd_a_v = 1'b1;
                end
                n_held   = '0;
                n_held_v = 1'b0;
                n_run    = '0;
                n_lit    = '0;
            end

            if (cmd_b_v) begin
                cmd_b.burst_end = 1'b1;
            end else if (cmd_a_v) begin
                cmd_a.burst_end = 1'b1;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    assign o_push     = r_pend_v ? !i_q_full : (accept && cmd_a_v);
    assign o_push_cmd = r_pend_v ? r_pend : cmd_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_run    <= '0;
            r_lit    <= '0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_run    <= n_run;
            r_lit    <= n_lit;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
            if (r_pend_v && !i_q_full) begin
                r_pend_v <= 1'b0;
            end
            if (accept && cmd_b_v) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cmd_b_v) begin
            r_pend <= cmd_b;
        end
    end

endmodule

// ----- rtl/core/pbrle_cmd_fifo.sv -----
module pbrle_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pbrle_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pbrle_pkg::t_cmd o_cmd
);

    import pbrle_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= PTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= PTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/pbrle_back.sv -----
module pbrle_back #(
    parameter int MAX_SPAN   = pbrle_pkg::MAX_SPAN_DEF,
    parameter int WORD_BYTES = pbrle_pkg::WORD_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  pbrle_pkg::t_cmd                 i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_rd_en,
    output logic [$clog2(MAX_SPAN):0]       o_rd_addr,
    input  logic [pbrle_pkg::BYTE_W-1:0]    i_rd_data,
    output pbrle_pkg::t_lit_release         o_release,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pbrle_pkg::OUT_W-1:0]     o_out_word,
    output logic [pbrle_pkg::OUT_CNT_W-1:0] o_out_count,
    output logic                            o_out_end
);

    import pbrle_pkg::*;

    localparam int IDX_W = $clog2(MAX_SPAN);
    localparam int CNT_W = $clog2(MAX_SPAN + 1);
    localparam int PK_W  = $clog2(WORD_BYTES + 1);
    localparam int ACC_W = WORD_BYTES * BYTE_W;

    function automatic logic [BYTE_W-1:0] f_header(input t_cmd c);
        if (c.kind == CMD_RUN) begin
            return BYTE_W'(RUN_HDR_BASE - 9'(c.len));
        end
        return BYTE_W'(c.len + LEN_W'(c.has_tail) - LEN_W'(1));
    endfunction

    // sequencer
    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_idx, n_idx;

    logic              em_v, em_ram, em_last;
    logic [BYTE_W-1:0] em_byte;
    logic              lit_end;
    logic              advance;

    // byte stage, data from the ram arrives here
    logic              r_s1_v, r_s1_ram, r_s1_bend, r_s1_send;
    logic [BYTE_W-1:0] r_s1_byte;

    // word packer and output register
    logic [ACC_W-1:0]     r_acc, n_acc, merged;
    logic [PK_W-1:0]      r_pk_cnt, n_pk_cnt;
    logic                 r_o_v, n_o_v;
    logic [OUT_W-1:0]     r_o_word, n_o_word;
    logic [OUT_CNT_W-1:0] r_o_count, n_o_count;
    logic                 r_o_end, n_o_end;

    logic [BYTE_W-1:0] s1_data;
    logic              completes, out_free, pk_take;

    assign lit_end = (CNT_W'(r_idx + 1'b1) == r_cmd.len[CNT_W-1:0]);
    assign advance = !r_s1_v || pk_take;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        o_q_pop   = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = {r_cmd.bank, r_idx[IDX_W-1:0]};
        o_release = '0;
        em_v      = 1'b0;
        em_ram    = 1'b0;
        em_last   = 1'b0;
        em_byte   = r_cmd.data;
        unique case (r_state) inside
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_state = BK_HDR;
                end
            end
            BK_HDR: begin
                em_v    = 1'b1;
                em_byte = f_header(r_cmd);
                if (advance) begin
                    if (r_cmd.kind == CMD_RUN) begin
                        n_state = BK_RUN;
                    end else if (r_cmd.len != '0) begin
                        n_state = BK_LIT;
                    end else begin
                        n_state = BK_TAIL;
                    end
                end
            end
            BK_RUN, BK_TAIL: begin
                em_v    = 1'b1;
                em_last = 1'b1;
                if (advance) begin
                    n_state = BK_IDLE;
                end
            end
            BK_LIT: begin
                em_v    = 1'b1;
                em_ram  = 1'b1;
                em_last = lit_end && !r_cmd.has_tail;
                if (advance) begin
                    o_rd_en = 1'b1;
                    if (lit_end) begin
                        o_release.valid = 1'b1;
                        o_release.bank  = r_cmd.bank;
                        n_state         = r_cmd.has_tail ? BK_TAIL : BK_IDLE;
                    end else begin
                        n_idx = CNT_W'(r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign s1_data   = r_s1_ram ? i_rd_data : r_s1_byte;
    assign completes = (r_pk_cnt == PK_W'(WORD_BYTES - 1)) || r_s1_bend;
    assign out_free  = !r_o_v || i_ready;
    assign pk_take   = r_s1_v && (!completes || out_free);

    always_comb begin
        merged = r_acc;
        for (int k = 0; k < WORD_BYTES; k++) begin
            if (PK_W'(k) == r_pk_cnt) begin
                merged[k*BYTE_W +: BYTE_W] = s1_data;
            end
        end
    end

    always_comb begin
        n_acc     = r_acc;
        n_pk_cnt  = r_pk_cnt;
        n_o_v     = r_o_v && !i_ready;
        n_o_word  = r_o_word;
        n_o_count = r_o_count;
        n_o_end   = r_o_end;
        if (pk_take) begin
            if (completes) begin
                n_acc     = '0;
                n_pk_cnt  = '0;
                n_o_v     = 1'b1;
                n_o_word  = OUT_W'(merged);
                n_o_count = OUT_CNT_W'(r_pk_cnt) + OUT_CNT_W'(1);
                n_o_end   = r_s1_send;
            end else begin
                n_acc    = merged;
                n_pk_cnt = PK_W'(r_pk_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_s1_v   <= 1'b0;
            r_acc    <= '0;
            r_pk_cnt <= '0;
            r_o_v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (advance) begin
                r_s1_v <= em_v;
            end
            r_acc    <= n_acc;
            r_pk_cnt <= n_pk_cnt;
            r_o_v    <= n_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_o_word  <= n_o_word;
        r_o_count <= n_o_count;
        r_o_end   <= n_o_end;
        if (advance) begin
            r_s1_ram  <= em_ram;
            r_s1_byte <= em_byte;
            r_s1_bend <= em_last && r_cmd.burst_end;
            r_s1_send <= em_last && r_cmd.stream_end;
        end
    end

    assign o_valid     = r_o_v;
    assign o_out_word  = r_o_word;
    assign o_out_count = r_o_count;
    assign o_out_end   = r_o_end;

endmodule

// ----- rtl/core/pbrle_checker.sv -----
module pbrle_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [pbrle_pkg::BYTE_W-1:0]    i_in_byte,
    input logic                            i_in_last,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [pbrle_pkg::OUT_W-1:0]     o_out_word,
    input logic [pbrle_pkg::OUT_CNT_W-1:0] o_out_count,
    input logic                            o_out_end
);

    // no word survives a reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_word)
            && $stable(o_out_count) && $stable(o_out_end))
        else $error("stalled output word changed");

    // a one-byte word carries nothing above its first lane
    a_single_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_count == 4'd1) |-> (o_out_word[63:8] == 56'd0))
        else $error("unused byte lanes not zero");

endmodule

bind packbits_rle_encoder_top pbrle_checker u_pbrle_checker (.*);

// ----- tb/packbits_rle_encoder_checker.sv -----
module packbits_rle_encoder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [pbrle_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                            i_in_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [pbrle_pkg::OUT_W-1:0]     i_out_word,
    input  logic [pbrle_pkg::OUT_CNT_W-1:0] i_out_count,
    input  logic                            i_out_end,
    output int                              o_mismatches,
    output int                              o_words_due
);

    import pbrle_pkg::*;

    localparam int SPAN       = MAX_SPAN_DEF;
    localparam int WORD_BYTES = WORD_BYTES_DEF;

    typedef struct {
        logic [OUT_W-1:0]     word;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } t_coded_word;

    t_coded_word       words_due[$];
    logic [BYTE_W-1:0] code_bytes[$];

    // encoder state
    logic [BYTE_W-1:0] held_byte;
    logic              held_valid;
    int                run_len;
    logic [BYTE_W-1:0] lit_buf[SPAN];
    int                lit_cnt;

    function automatic void close_run();
        if (run_len != 0) begin
            code_bytes = {code_bytes, BYTE_W'(int'(RUN_HDR_BASE) - run_len)};
            code_bytes = {code_bytes, held_byte};
            run_len = 0;
        end
    endfunction

    function automatic void close_literal();
        if (lit_cnt != 0) begin
            code_bytes = {code_bytes, BYTE_W'(lit_cnt - 1)};
            for (int k = 0; k < lit_cnt; k++) code_bytes = {code_bytes, lit_buf[k]};
            lit_cnt = 0;
        end
    endfunction

    function automatic void add_literal(logic [BYTE_W-1:0] b);
        lit_buf[lit_cnt] = b;
        lit_cnt++;
        if (lit_cnt >= SPAN) close_literal();
    endfunction

    // codes caused by one raw byte, packed into output words
    function automatic void encode_byte(logic [BYTE_W-1:0] b, logic last);
        t_coded_word cw;
        int          n;
        code_bytes.delete();
        if (!held_valid) begin
            held_byte  = b;
            held_valid = 1'b1;
        end else if (run_len != 0) begin
            if (b == held_byte && run_len < SPAN) begin
                run_len++;
            end else begin
                close_run();
                held_byte = b;
            end
        end else if (b == held_byte) begin
            close_literal();
            run_len = MIN_RUN;
        end else begin
            add_literal(held_byte);
            held_byte = b;
        end
        if (last) begin
            if (run_len != 0) begin
                close_run();
            end else begin
                add_literal(held_byte);
                close_literal();
            end
            held_byte  = '0;
            held_valid = 1'b0;
        end
        for (int pos = 0; pos < code_bytes.size(); pos += WORD_BYTES) begin
            n = code_bytes.size() - pos;
            if (n > WORD_BYTES) n = WORD_BYTES;
            cw.word = '0;
            for (int k = 0; k < n; k++) cw.word[8*k +: 8] = code_bytes[pos + k];
            cw.count = OUT_CNT_W'(n);
            cw.last  = last && (pos + n >= code_bytes.size());
            words_due = {words_due, cw};
        end
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_coded_word due;
        if (!i_rst_n) begin
            held_byte    = '0;
            held_valid   = 1'b0;
            run_len      = 0;
            lit_cnt      = 0;
            o_mismatches = 0;
            words_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) encode_byte(i_in_byte, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word", i_out_word, '0);
                end else begin
                    due = words_due.pop_front();
                    if (i_out_word !== due.word)
                        report_mismatch("out_word", i_out_word, due.word);
                    if (i_out_count !== due.count)
                        report_mismatch("out_count", OUT_W'(i_out_count), OUT_W'(due.count));
                    if (i_out_end !== due.last)
                        report_mismatch("out_end", OUT_W'(i_out_end), OUT_W'(due.last));
                end
            end
        end
        o_words_due <= words_due.size();
    end

endmodule

// ----- tb/packbits_rle_encoder_top_test.sv -----
module packbits_rle_encoder_top_test;
    import pbrle_pkg::*;

    // clock and reset
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;

    // input channel, idle from time zero
    logic                 i_valid   = 1'b0;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_in_byte = '0;
    logic                 i_in_last = 1'b0;

    // output channel
    logic                 o_valid;
    logic                 i_ready   = 1'b0;
    logic [OUT_W-1:0]     o_out_word;
    logic [OUT_CNT_W-1:0] o_out_count;
    logic                 o_out_end;

    // results from the checker
    int                   mismatches;
    int                   words_due;

    // while set, neither side idles: a long stretch at full rate
    bit                   steady = 1'b0;
    int                   bytes_sent = 0;

    always #5 i_clk = ~i_clk;

    packbits_rle_encoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_word  (o_out_word),
        .o_out_count (o_out_count),
        .o_out_end   (o_out_end)
    );

    packbits_rle_encoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_out_word),
        .i_out_count  (o_out_count),
        .i_out_end    (o_out_end),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    // receiver stalls at random, about 13 percent of the time, never while steady
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 13);
    end

    // offer one raw byte and hold it until the word is taken; a one-cycle gap
    // with valid low may come first
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (!steady && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // one random stream built from short runs, short literals and noise;
    // long_kind adds one segment of 127 to 131 bytes, around the span limit:
    // 1 = long run, 2 = long literal with no equal neighbors
    task automatic send_stream(input int long_kind);
        logic [BYTE_W-1:0] raw[$];
        logic [BYTE_W-1:0] b;
        int                segs;
        int                long_at;
        int                len;
        segs    = $urandom_range(1, 8);
        long_at = $urandom_range(0, segs - 1);
        for (int s = 0; s < segs; s++) begin
            if (s == long_at && long_kind == 1) begin
                b   = BYTE_W'($urandom_range(0, 255));
                len = $urandom_range(127, 131);
                repeat (len) raw = {raw, b};
            end else if (s == long_at && long_kind == 2) begin
                b   = BYTE_W'($urandom_range(0, 255));
                len = $urandom_range(127, 131);
                repeat (len) begin
                    // a nonzero step keeps neighbors distinct
                    b = b + BYTE_W'($urandom_range(1, 255));
                    raw = {raw, b};
                end
            end else begin
                case ($urandom_range(2))
                    0: begin
                        // short run, sometimes of the byte before it
                        if (raw.size() != 0 && $urandom_range(3) == 0) b = raw[$];
                        else b = BYTE_W'($urandom_range(0, 255));
                        repeat ($urandom_range(1, 5)) raw = {raw, b};
                    end
                    1: begin
                        // narrow alphabet makes chance pairs
                        repeat ($urandom_range(1, 6))
                            raw = {raw, BYTE_W'($urandom_range(0, 3))};
                    end
                    default: begin
                        repeat ($urandom_range(1, 6))
                            raw = {raw, BYTE_W'($urandom_range(0, 255))};
                    end
                endcase
            end
        end
        for (int i = 0; i < raw.size(); i++) send_byte(raw[i], i == raw.size() - 1);
    endtask

    initial begin
        // reset at the start, then never again
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte streams at both byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // run of two closed by the end of stream
        send_byte(8'ha5, 1'b0);
        send_byte(8'ha5, 1'b1);
        // literal of two
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b1);
        // run broken by a different byte, which ends as a one-byte literal
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        // literal closed by an equal pair
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'hfe, 1'b1);
        // literal, run, literal in one stream
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b1);
        // all-ones run into all-zeros
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);

        // random streams; one long run at full rate, one long literal
        send_stream(0);
        steady = 1'b1;
        send_stream(1);
        steady = 1'b0;
        send_stream(2);
        while (bytes_sent < 370) send_stream(0);
        i_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        do @(posedge i_clk); while (words_due != 0);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && words_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- packbits_rle_encoder_top.f -----
rtl/core/pbrle_pkg.sv
rtl/core/pbrle_ram.sv
rtl/core/pbrle_front.sv
rtl/core/pbrle_cmd_fifo.sv
rtl/core/pbrle_back.sv
rtl/core/packbits_rle_encoder_top.sv
rtl/core/pbrle_checker.sv
tb/packbits_rle_encoder_checker.sv
tb/packbits_rle_encoder_top_test.sv
